// File: design/ffa_pkg.sv
// Shared types, widths and codes for the fault flag aggregator.
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int FAULT_COUNT = 32;
  localparam int FLAG_W      = 32;
  localparam int TIMER_W     = 24;
  localparam int DELTA_W     = 16;
  localparam int COUNT_W     = 16;
  localparam int SEL_W       = 5;
  localparam int SEV_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MISSION_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGRADED_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STICKY_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_HOLD = 3'd4;

  localparam logic [SEV_W-1:0] SEV_NONE     = 3'd0;
  localparam logic [SEV_W-1:0] SEV_WARNING  = 3'd1;
  localparam logic [SEV_W-1:0] SEV_DEGRADED = 3'd2;
  localparam logic [SEV_W-1:0] SEV_CRITICAL = 3'd3;
  localparam logic [SEV_W-1:0] SEV_MISSION  = 3'd4;

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_RAISE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic eval;
    logic commit;
    logic raise;
  } lane_ctrl_t;

  typedef struct packed {
    logic [FLAG_W-1:0]  active_flags;
    logic [FLAG_W-1:0]  latched_flags;
    logic [FLAG_W-1:0]  changed_flags;
    logic [SEV_W-1:0]   severity;
    logic               fault_changed;
    logic [COUNT_W-1:0] selected_count;
  } result_t;

endpackage

// File: design/ffa_lane.sv
// One fault lane: recovery hold timer, next active bit and occurrence counter.
`timescale 1ns / 1ps

module ffa_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ffa_pkg::lane_ctrl_t              ctrl,
  input  logic                             raw_bit,
  input  logic                             active_bit,
  input  logic                             sticky_bit,
  input  logic [ffa_pkg::DELTA_W-1:0]      delta,
  input  logic [ffa_pkg::TIMER_W-1:0]      hold,
  output logic                             pend_bit,
  output logic [ffa_pkg::COUNT_W-1:0]      count_out
);

  logic [ffa_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic [ffa_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        pend_r, pend_nxt;
  logic [ffa_pkg::TIMER_W:0]   sum;
  logic [ffa_pkg::TIMER_W-1:0] sat_sum;
  logic                        hit;
  logic                        rising;

  assign sum     = {1'b0, timer_r} + {{(ffa_pkg::TIMER_W + 1 - ffa_pkg::DELTA_W){1'b0}}, delta};
  assign sat_sum = sum[ffa_pkg::TIMER_W] ? {ffa_pkg::TIMER_W{1'b1}} : sum[ffa_pkg::TIMER_W-1:0];
  assign hit     = raw_bit | (active_bit & sticky_bit);

  always_comb begin
    timer_nxt = timer_r;
    pend_nxt  = pend_r;
    if (ctrl.eval) begin
      if (ctrl.raise) begin
        pend_nxt = active_bit | raw_bit;
      end else if (hit) begin
        timer_nxt = '0;
        pend_nxt  = 1'b1;
      end else if (active_bit) begin
        timer_nxt = sat_sum;
        pend_nxt  = (sat_sum < hold);
      end else begin
        timer_nxt = '0;
        pend_nxt  = 1'b0;
      end
    end
  end

  assign rising = pend_r & ~active_bit;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.commit && rising && (count_r != {ffa_pkg::COUNT_W{1'b1}})) begin
      count_nxt = count_r + (ffa_pkg::COUNT_W)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      timer_r <= timer_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign pend_bit  = pend_r;
  assign count_out = count_nxt;

endmodule

// File: design/ffa_merge.sv
// Merging stage: change report, latched set, severity grade and counter selection.
`timescale 1ns / 1ps

module ffa_merge (
  input  logic [ffa_pkg::FLAG_W-1:0]  new_set,
  input  logic [ffa_pkg::FLAG_W-1:0]  active_set,
  input  logic [ffa_pkg::FLAG_W-1:0]  latched_set,
  input  logic [ffa_pkg::FLAG_W-1:0]  mission_mask,
  input  logic [ffa_pkg::FLAG_W-1:0]  critical_mask,
  input  logic [ffa_pkg::FLAG_W-1:0]  degraded_mask,
  input  logic [ffa_pkg::COUNT_W-1:0] counts [ffa_pkg::FLAG_W],
  input  logic [ffa_pkg::SEL_W-1:0]   sel,
  output ffa_pkg::result_t            res
);

  logic [ffa_pkg::FLAG_W-1:0] changed;

  assign changed = new_set ^ active_set;

  always_comb begin
    res.active_flags   = new_set;
    res.latched_flags  = latched_set | new_set;
    res.changed_flags  = changed;
    res.fault_changed  = |changed;
    res.selected_count = counts[sel];
    if (|(new_set & mission_mask)) begin
      res.severity = ffa_pkg::SEV_MISSION;
    end else if (|(new_set & critical_mask)) begin
      res.severity = ffa_pkg::SEV_CRITICAL;
    end else if (|(new_set & degraded_mask)) begin
      res.severity = ffa_pkg::SEV_DEGRADED;
    end else if (|new_set) begin
      res.severity = ffa_pkg::SEV_WARNING;
    end else begin
      res.severity = ffa_pkg::SEV_NONE;
    end
  end

endmodule

// File: design/fault_flag_aggregator.sv
// Top level of the fault flag aggregator: sequencer, fault lanes and result register.
`timescale 1ns / 1ps

// A word is accepted only while the sequencer is idle. In the cycle after acceptance every
// fault lane decides its next active bit and, on a step request, updates its healthy timer;
// then, once no earlier result is waiting, the lanes count rising edges and the merging
// stage commits the set into the result register.
// The commit waits while an earlier result has not yet been taken, so a new word is
// accepted as soon as the sequencer is idle, even with a result still on the output.
// A new word is therefore not accepted until the previous one has been committed.
module fault_flag_aggregator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ffa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [ffa_pkg::FLAG_W-1:0]          in_fault_bits,
  input  logic [ffa_pkg::DELTA_W-1:0]         in_step_delta_us,
  input  logic [ffa_pkg::SEL_W-1:0]           in_count_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ffa_pkg::FLAG_W-1:0]          out_active_flags,
  output logic [ffa_pkg::FLAG_W-1:0]          out_latched_flags,
  output logic [ffa_pkg::FLAG_W-1:0]          out_changed_flags,
  output logic [ffa_pkg::SEV_W-1:0]           out_severity,
  output logic                                out_fault_changed,
  output logic [ffa_pkg::COUNT_W-1:0]         out_selected_count
);

  logic [ffa_pkg::FLAG_W-1:0]  mission_mask_r, critical_mask_r, degraded_mask_r, sticky_mask_r;
  logic [ffa_pkg::TIMER_W-1:0] hold_r;

  ffa_pkg::state_t state_r, state_nxt;

  logic                        req_r;
  logic [ffa_pkg::FLAG_W-1:0]  bits_r;
  logic [ffa_pkg::DELTA_W-1:0] delta_r;
  logic [ffa_pkg::SEL_W-1:0]   sel_r;

  logic [ffa_pkg::FLAG_W-1:0]  active_r, latched_r;
  logic                        out_valid_r, out_valid_nxt;
  ffa_pkg::result_t            res_r, res;

  logic                        accept;
  logic                        commit_go;
  ffa_pkg::lane_ctrl_t         ctrl;
  logic [ffa_pkg::FLAG_W-1:0]  pend_vec;
  logic [ffa_pkg::COUNT_W-1:0] cnt_vec [ffa_pkg::FLAG_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mission_mask_r  <= '0;
      critical_mask_r <= '0;
      degraded_mask_r <= '0;
      sticky_mask_r   <= '0;
      hold_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffa_pkg::CFG_MISSION_MASK:  mission_mask_r  <= cfg_wdata;
        ffa_pkg::CFG_CRITICAL_MASK: critical_mask_r <= cfg_wdata;
        ffa_pkg::CFG_DEGRADED_MASK: degraded_mask_r <= cfg_wdata;
        ffa_pkg::CFG_STICKY_MASK:   sticky_mask_r   <= cfg_wdata;
        ffa_pkg::CFG_RECOVERY_HOLD: hold_r          <= cfg_wdata[ffa_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept    = in_valid && in_ready;
  assign commit_go = (state_r == ffa_pkg::ST_COMMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffa_pkg::ST_IDLE:   if (in_valid) state_nxt = ffa_pkg::ST_EVAL;
      ffa_pkg::ST_EVAL:   state_nxt = ffa_pkg::ST_COMMIT;
      ffa_pkg::ST_COMMIT: if (!out_valid_r || out_ready) state_nxt = ffa_pkg::ST_IDLE;
      default:            state_nxt = ffa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctrl.eval   = 1'b0;
    ctrl.commit = 1'b0;
    ctrl.raise  = (req_r == ffa_pkg::REQ_RAISE);
    unique case (state_r)
      ffa_pkg::ST_IDLE:   in_ready    = 1'b1;
      ffa_pkg::ST_EVAL:   ctrl.eval   = 1'b1;
      ffa_pkg::ST_COMMIT: ctrl.commit = commit_go;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      latched_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit_go) begin
        active_r  <= res.active_flags;
        latched_r <= res.latched_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      bits_r  <= in_fault_bits;
      delta_r <= in_step_delta_us;
      sel_r   <= in_count_index;
    end
    if (commit_go) begin
      res_r <= res;
    end
  end

  for (genvar g = 0; g < ffa_pkg::FLAG_W; g++) begin : g_bit
    if (g < ffa_pkg::FAULT_COUNT) begin : g_lane
      ffa_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .raw_bit    (bits_r[g]),
        .active_bit (active_r[g]),
        .sticky_bit (sticky_mask_r[g]),
        .delta      (delta_r),
        .hold       (hold_r),
        .pend_bit   (pend_vec[g]),
        .count_out  (cnt_vec[g])
      );
    end else begin : g_pass
      logic pass_r;
      always_ff @(posedge clk) begin
        if (ctrl.eval) begin
          pass_r <= ctrl.raise ? (active_r[g] | bits_r[g])
                               : (bits_r[g] | (active_r[g] & sticky_mask_r[g]));
        end
      end
      assign pend_vec[g] = pass_r;
      assign cnt_vec[g]  = '0;
    end
  end

  ffa_merge u_merge (
    .new_set       (pend_vec),
    .active_set    (active_r),
    .latched_set   (latched_r),
    .mission_mask  (mission_mask_r),
    .critical_mask (critical_mask_r),
    .degraded_mask (degraded_mask_r),
    .counts        (cnt_vec),
    .sel           (sel_r),
    .res           (res)
  );

  assign out_valid          = out_valid_r;
  assign out_active_flags   = res_r.active_flags;
  assign out_latched_flags  = res_r.latched_flags;
  assign out_changed_flags  = res_r.changed_flags;
  assign out_severity       = res_r.severity;
  assign out_fault_changed  = res_r.fault_changed;
  assign out_selected_count = res_r.selected_count;

  // Every committed active bit must also be present in the latched set.
  a_latched_covers_active: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~latched_r) == '0)
    else $error("active set holds a bit that is not latched");

  // An accepted word always moves the sequencer into evaluation.
  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ffa_pkg::ST_EVAL))
    else $error("accepted word did not start evaluation");

  // A commit leaves the output register holding the committed active set.
  a_commit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> (out_valid_r && (res_r.active_flags == active_r)))
    else $error("output register does not match the committed set");

  // The change flag agrees with the reported changed bits.
  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.fault_changed == (res_r.changed_flags != '0)))
    else $error("change flag disagrees with changed bits");

  // No severity is reported exactly when the active set is empty.
  a_severity_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.severity == ffa_pkg::SEV_NONE) == (res_r.active_flags == '0)))
    else $error("severity grade disagrees with the active set");

endmodule
